// ----- rtl/plr_pkg.sv -----
// shared types and codes for the patterned line rasterizer
package plr_pkg;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } op_t;

  typedef struct packed {
    logic x_step_negative;
    logic y_step_negative;
    logic x_is_major;
  } line_flags_t;

  localparam logic [15:0] PATTERN_MASK_RESET = 16'hFFFF;

endpackage

// ----- rtl/plr_load.sv -----
// endpoint decode for a load beat: wrapped points, deltas, step signs, major axis
module plr_load #(
  parameter int COORD_BITS = 16
) (
  input  logic signed [15:0]       start_x,
  input  logic signed [15:0]       start_y,
  input  logic signed [15:0]       end_x,
  input  logic signed [15:0]       end_y,
  output logic [COORD_BITS-1:0]    cur_x,
  output logic [COORD_BITS-1:0]    cur_y,
  output logic [COORD_BITS-1:0]    target_x,
  output logic [COORD_BITS-1:0]    target_y,
  output logic [COORD_BITS:0]      delta_x,
  output logic [COORD_BITS:0]      delta_y,
  output plr_pkg::line_flags_t     flags
);
  import plr_pkg::*;

  localparam int CW = COORD_BITS;

  logic signed [CW-1:0] sx, sy, ex, ey;
  logic signed [CW:0]   dx, dy;

  // sign extend or wrap the 16 bit inputs to the coordinate width
  assign sx = CW'(start_x);
  assign sy = CW'(start_y);
  assign ex = CW'(end_x);
  assign ey = CW'(end_y);

  assign dx = (CW+1)'(ex) - (CW+1)'(sx);
  assign dy = (CW+1)'(ey) - (CW+1)'(sy);

  assign delta_x = dx[CW] ? $unsigned(-dx) : $unsigned(dx);
  assign delta_y = dy[CW] ? $unsigned(-dy) : $unsigned(dy);

  assign flags.x_step_negative = dx[CW];
  assign flags.y_step_negative = dy[CW];
  assign flags.x_is_major      = (delta_x >= delta_y);

  assign cur_x    = $unsigned(sx);
  assign cur_y    = $unsigned(sy);
  assign target_x = $unsigned(ex);
  assign target_y = $unsigned(ey);

endmodule

// ----- rtl/plr_step.sv -----
// one pixel step: pattern test, result pixel and the next walker state
module plr_step #(
  parameter int COORD_BITS = 16
) (
  input  logic [COORD_BITS-1:0]    cur_x,
  input  logic [COORD_BITS-1:0]    cur_y,
  input  logic [COORD_BITS-1:0]    target_x,
  input  logic [COORD_BITS-1:0]    target_y,
  input  logic [COORD_BITS:0]      delta_x,
  input  logic [COORD_BITS:0]      delta_y,
  input  plr_pkg::line_flags_t     flags,
  input  logic [COORD_BITS:0]      minor_accum,
  input  logic [COORD_BITS:0]      balance_accum,
  input  logic                     busy,
  input  logic [15:0]              pattern_mask,
  output logic [COORD_BITS-1:0]    cur_x_next,
  output logic [COORD_BITS-1:0]    cur_y_next,
  output logic [COORD_BITS:0]      minor_accum_next,
  output logic [COORD_BITS:0]      balance_accum_next,
  output logic                     busy_next,
  output logic                     plot,
  output logic signed [15:0]       pixel_x,
  output logic signed [15:0]       pixel_y,
  output logic                     finished
);
  import plr_pkg::*;

  localparam int CW = COORD_BITS;
  localparam int AW = COORD_BITS + 1;

  function automatic logic [15:0] to16(input logic [CW-1:0] c);
    logic signed [CW-1:0] s;
    s = $signed(c);
    return 16'(s);
  endfunction

  logic [CW-1:0] major_c, minor_c, major_c_next, minor_c_next;
  logic          major_neg, minor_neg;
  logic [CW:0]   major_d, minor_d;
  logic          major_done;
  logic          take_minor;
  logic [AW:0]   bal_sum;
  logic [AW-1:0] minor_base;
  logic [15:0]   hit_x, hit_y, pat_sum;

  assign major_c   = flags.x_is_major ? cur_x : cur_y;
  assign minor_c   = flags.x_is_major ? cur_y : cur_x;
  assign major_neg = flags.x_is_major ? flags.x_step_negative : flags.y_step_negative;
  assign minor_neg = flags.x_is_major ? flags.y_step_negative : flags.x_step_negative;
  assign major_d   = flags.x_is_major ? delta_x : delta_y;
  assign minor_d   = flags.x_is_major ? delta_y : delta_x;

  assign major_done = flags.x_is_major ? (cur_x == target_x) : (cur_y == target_y);

  // two-accumulator error rule
  assign take_minor = (minor_accum > balance_accum);
  assign bal_sum    = (AW+1)'(balance_accum) + (AW+1)'(major_d) - (AW+1)'(minor_accum);
  assign minor_base = take_minor ? '0 : minor_accum;

  assign major_c_next = major_neg ? major_c - CW'(1) : major_c + CW'(1);
  assign minor_c_next = take_minor ? (minor_neg ? minor_c - CW'(1) : minor_c + CW'(1))
                                   : minor_c;

  // pattern test on target on the end pixel, on the current point otherwise
  assign hit_x   = major_done ? to16(target_x) : to16(cur_x);
  assign hit_y   = major_done ? to16(target_y) : to16(cur_y);
  assign pat_sum = (flags.x_step_negative == flags.y_step_negative) ? hit_x + hit_y
                                                                    : hit_x - hit_y;

  always_comb begin
    cur_x_next         = cur_x;
    cur_y_next         = cur_y;
    minor_accum_next   = minor_accum;
    balance_accum_next = balance_accum;
    busy_next          = busy;
    plot               = 1'b0;
    pixel_x            = $signed(to16(cur_x));
    pixel_y            = $signed(to16(cur_y));
    finished           = 1'b1;
    if (busy && major_done) begin
      plot       = |(pat_sum & pattern_mask);
      pixel_x    = $signed(to16(target_x));
      pixel_y    = $signed(to16(target_y));
      cur_x_next = target_x;
      cur_y_next = target_y;
      busy_next  = 1'b0;
    end else if (busy) begin
      plot             = |(pat_sum & pattern_mask);
      finished         = 1'b0;
      minor_accum_next = minor_base + minor_d;
      if (take_minor) begin
        balance_accum_next = AW'(bal_sum);
      end
      if (flags.x_is_major) begin
        cur_x_next = major_c_next;
        cur_y_next = minor_c_next;
      end else begin
        cur_x_next = minor_c_next;
        cur_y_next = major_c_next;
      end
    end
  end

endmodule

// ----- rtl/patterned_line_rasterizer.sv -----
// top level of the patterned line rasterizer: beat registers, line state, config
//
//   channel  dir  handshake               payload
//   in       in   in_valid / in_stall     operation, start_x, start_y, end_x, end_y
//   out      out  out_valid / out_stall   plot, pixel_x, pixel_y, finished
//   cfg      in   cfg_valid / cfg_ready   cfg_data (pattern_mask)
//
// one beat per cycle sustained while in_stall stays low; a step beat is taken into the input
//   beat register, and its pixel is then registered in the result register for the out side
// the per-pixel add and compare sits between the line state registers and the result register
// load beats make no pixel and never wait on the out side
// rst clears the line state to idle at the origin and the pattern mask to all ones
// a stalled result holds in place; in_stall rises only when a step beat meets a full,
//   stalled result register
module patterned_line_rasterizer #(
  parameter int COORD_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               operation,
  input  logic signed [15:0] start_x,
  input  logic signed [15:0] start_y,
  input  logic signed [15:0] end_x,
  input  logic signed [15:0] end_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               plot,
  output logic signed [15:0] pixel_x,
  output logic signed [15:0] pixel_y,
  output logic               finished,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_data
);
  import plr_pkg::*;

  localparam int CW = COORD_BITS;

  // input beat register
  logic               hold_valid;
  op_t                hold_op;
  logic signed [15:0] hold_start_x, hold_start_y, hold_end_x, hold_end_y;
  logic               hold_fire;
  logic               in_accept;

  // line state
  logic [CW-1:0] cur_x, cur_y, target_x, target_y;
  logic [CW:0]   delta_x, delta_y;
  line_flags_t   flags;
  logic [CW:0]   minor_accum, balance_accum;
  logic          busy;
  logic [15:0]   pattern_mask;

  // load decode
  logic [CW-1:0] ld_cur_x, ld_cur_y, ld_target_x, ld_target_y;
  logic [CW:0]   ld_delta_x, ld_delta_y;
  line_flags_t   ld_flags;

  // step results
  logic [CW-1:0]      cur_x_next, cur_y_next;
  logic [CW:0]        minor_accum_next, balance_accum_next;
  logic               busy_next;
  logic               st_plot, st_finished;
  logic signed [15:0] st_pixel_x, st_pixel_y;

  // a load always moves on; a step needs room in the result register
  assign hold_fire = hold_valid && ((hold_op == OP_LOAD) || !out_valid || !out_stall);
  assign in_stall  = hold_valid && !hold_fire;
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!in_stall) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      hold_op      <= op_t'(operation);
      hold_start_x <= start_x;
      hold_start_y <= start_y;
      hold_end_x   <= end_x;
      hold_end_y   <= end_y;
    end
  end

  plr_load #(.COORD_BITS(COORD_BITS)) u_load (
    .start_x  (hold_start_x),
    .start_y  (hold_start_y),
    .end_x    (hold_end_x),
    .end_y    (hold_end_y),
    .cur_x    (ld_cur_x),
    .cur_y    (ld_cur_y),
    .target_x (ld_target_x),
    .target_y (ld_target_y),
    .delta_x  (ld_delta_x),
    .delta_y  (ld_delta_y),
    .flags    (ld_flags)
  );

  plr_step #(.COORD_BITS(COORD_BITS)) u_step (
    .cur_x              (cur_x),
    .cur_y              (cur_y),
    .target_x           (target_x),
    .target_y           (target_y),
    .delta_x            (delta_x),
    .delta_y            (delta_y),
    .flags              (flags),
    .minor_accum        (minor_accum),
    .balance_accum      (balance_accum),
    .busy               (busy),
    .pattern_mask       (pattern_mask),
    .cur_x_next         (cur_x_next),
    .cur_y_next         (cur_y_next),
    .minor_accum_next   (minor_accum_next),
    .balance_accum_next (balance_accum_next),
    .busy_next          (busy_next),
    .plot               (st_plot),
    .pixel_x            (st_pixel_x),
    .pixel_y            (st_pixel_y),
    .finished           (st_finished)
  );

  // line state updates when the held beat moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x         <= '0;
      cur_y         <= '0;
      target_x      <= '0;
      target_y      <= '0;
      delta_x       <= '0;
      delta_y       <= '0;
      flags         <= '0;
      minor_accum   <= '0;
      balance_accum <= '0;
      busy          <= 1'b0;
    end else if (hold_fire) begin
      if (hold_op == OP_LOAD) begin
        // a load replaces any line in progress
        cur_x         <= ld_cur_x;
        cur_y         <= ld_cur_y;
        target_x      <= ld_target_x;
        target_y      <= ld_target_y;
        delta_x       <= ld_delta_x;
        delta_y       <= ld_delta_y;
        flags         <= ld_flags;
        minor_accum   <= '0;
        balance_accum <= '0;
        busy          <= 1'b1;
      end else begin
        cur_x         <= cur_x_next;
        cur_y         <= cur_y_next;
        minor_accum   <= minor_accum_next;
        balance_accum <= balance_accum_next;
        busy          <= busy_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (hold_fire && (hold_op == OP_STEP)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (hold_fire && (hold_op == OP_STEP)) begin
      plot     <= st_plot;
      pixel_x  <= st_pixel_x;
      pixel_y  <= st_pixel_y;
      finished <= st_finished;
    end
  end

  // dash pattern register
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_mask <= PATTERN_MASK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      pattern_mask <= cfg_data;
    end
  end

`ifndef NO_ASSERTIONS
  // a step beat never overwrites a result that is still stalled
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (hold_valid && (hold_op == OP_STEP) && out_valid && out_stall) |-> in_stall)
    else $error("step beat would overwrite a stalled result");

  // a load starts a fresh line with cleared accumulators
  a_load_clears: assert property (@(posedge clk) disable iff (rst)
    (hold_fire && (hold_op == OP_LOAD)) |=>
      (busy && (minor_accum == '0) && (balance_accum == '0)))
    else $error("load did not start a fresh line");

  // a step while idle gives a finished, blank pixel
  a_idle_step: assert property (@(posedge clk) disable iff (rst)
    (hold_fire && (hold_op == OP_STEP) && !busy) |=> (out_valid && finished && !plot))
    else $error("idle step did not report finished");
`endif

endmodule

// ----- tb/tb_patterned_line_rasterizer.sv -----
// self-checking testbench for the patterned line rasterizer
`timescale 1ns / 1ps

module tb_patterned_line_rasterizer;
  import plr_pkg::*;

  // one emitted pixel as seen on the out channel
  typedef struct packed {
    logic        plot;
    logic [15:0] x;
    logic [15:0] y;
    logic        fin;
  } pixel_t;

  // line walker mirror plus the queue of pixels still owed by the block
  class pixel_scoreboard;
    logic [15:0] mask;
    logic [15:0] cur_x, cur_y, tgt_x, tgt_y;
    logic [16:0] dlt_x, dlt_y;
    logic        neg_x, neg_y, x_major, busy;
    longint      minor_acc, balance_acc;
    pixel_t      owed_q[$];
    int          errors;

    function new();
      mask = PATTERN_MASK_RESET;
      cur_x = '0; cur_y = '0; tgt_x = '0; tgt_y = '0;
      dlt_x = '0; dlt_y = '0;
      neg_x = 1'b0; neg_y = 1'b0; x_major = 1'b0; busy = 1'b0;
      minor_acc = 0; balance_acc = 0;
      errors = 0;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    // one step along an axis, modulo 2^16
    function logic [15:0] walk(logic [15:0] c, logic neg);
      return c + (neg ? 16'hFFFF : 16'h0001);
    endfunction

    // slope-signed sum of the coordinates against the dash mask
    function logic dash_hit(logic [15:0] x, logic [15:0] y);
      logic [15:0] sum;
      sum = (neg_x == neg_y) ? x + y : x - y;
      return |(sum & mask);
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    // accepted input beat: update the line state and owe a pixel for a step
    function void note_beat(op_t op, logic [15:0] sx, logic [15:0] sy,
                            logic [15:0] ex, logic [15:0] ey);
      logic signed [16:0] dx, dy;
      pixel_t px;
      if (op == OP_LOAD) begin
        dx = $signed({ex[15], ex}) - $signed({sx[15], sx});
        dy = $signed({ey[15], ey}) - $signed({sy[15], sy});
        neg_x = dx[16];
        neg_y = dy[16];
        dlt_x = neg_x ? 17'(-dx) : 17'(dx);
        dlt_y = neg_y ? 17'(-dy) : 17'(dy);
        x_major = dlt_x >= dlt_y;
        cur_x = sx; cur_y = sy; tgt_x = ex; tgt_y = ey;
        minor_acc = 0;
        balance_acc = 0;
        busy = 1'b1;
        return;
      end
      if (!busy) begin
        px = '{1'b0, cur_x, cur_y, 1'b1};
      end else if (x_major ? (cur_x == tgt_x) : (cur_y == tgt_y)) begin
        px = '{dash_hit(tgt_x, tgt_y), tgt_x, tgt_y, 1'b1};
        cur_x = tgt_x;
        cur_y = tgt_y;
        busy = 1'b0;
      end else begin
        px = '{dash_hit(cur_x, cur_y), cur_x, cur_y, 1'b0};
        if (x_major) begin
          if (minor_acc > balance_acc) begin
            balance_acc += longint'(dlt_x) - minor_acc;
            minor_acc = 0;
            cur_y = walk(cur_y, neg_y);
          end
          minor_acc += longint'(dlt_y);
          cur_x = walk(cur_x, neg_x);
        end else begin
          if (minor_acc > balance_acc) begin
            balance_acc += longint'(dlt_y) - minor_acc;
            minor_acc = 0;
            cur_x = walk(cur_x, neg_x);
          end
          minor_acc += longint'(dlt_x);
          cur_y = walk(cur_y, neg_y);
        end
      end
      owed_q.push_back(px);
    endfunction

    // accepted output beat against the oldest owed pixel
    function void check_pixel(pixel_t got);
      pixel_t exp_px;
      if (owed_q.size() == 0) begin
        flag($sformatf("unexpected pixel: plot=%0b x=%0d y=%0d fin=%0b",
                       got.plot, $signed(got.x), $signed(got.y), got.fin));
        return;
      end
      exp_px = owed_q.pop_front();
      if (got !== exp_px)
        flag($sformatf({"pixel mismatch: expected plot=%0b x=%0d y=%0d fin=%0b, ",
                        "got plot=%0b x=%0d y=%0d fin=%0b"},
                       exp_px.plot, $signed(exp_px.x), $signed(exp_px.y), exp_px.fin,
                       got.plot, $signed(got.x), $signed(got.y), got.fin));
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               operation = OP_LOAD;
  logic signed [15:0] start_x = '0;
  logic signed [15:0] start_y = '0;
  logic signed [15:0] end_x = '0;
  logic signed [15:0] end_y = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               plot;
  logic signed [15:0] pixel_x;
  logic signed [15:0] pixel_y;
  logic               finished;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [15:0]        cfg_data = '0;

  pixel_scoreboard sb = new();

  // idle rates in percent for the sender gaps and the receiver stalls
  int send_gap_pct = 9;
  int recv_stall_pct = 48;
  int beats_sent = 0;

  patterned_line_rasterizer #(.COORD_BITS(16)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .start_x   (start_x),
    .start_y   (start_y),
    .end_x     (end_x),
    .end_y     (end_y),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .plot      (plot),
    .pixel_x   (pixel_x),
    .pixel_y   (pixel_y),
    .finished  (finished),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // out side: check the beat taken at this edge, then pick the next stall
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_pixel('{plot, pixel_x, pixel_y, finished});
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // present one input beat and hold it until taken; valid stays high for a follow-on beat
  task automatic send_beat(input op_t op, input logic [15:0] sx, input logic [15:0] sy,
                           input logic [15:0] ex, input logic [15:0] ey);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    start_x   <= sx;
    start_y   <= sy;
    end_x     <= ex;
    end_y     <= ey;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_beat(op, sx, sy, ex, ey);
    beats_sent++;
  endtask

  // step beats carry random don't-care endpoint fields
  task automatic send_step();
    send_beat(OP_STEP, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  // load a line, then step until its end pixel or the step cap
  task automatic draw_line(input logic [15:0] sx, input logic [15:0] sy,
                           input logic [15:0] ex, input logic [15:0] ey,
                           input int max_steps);
    int n;
    n = 0;
    send_beat(OP_LOAD, sx, sy, ex, ey);
    while (sb.busy && n < max_steps) begin
      send_step();
      n++;
    end
  endtask

  // sender pauses until every owed pixel is out, plus room for a load in flight
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // single register write; only called with the block drained
  task automatic write_mask(input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.mask = value;
  endtask

  // short random offset, now and then a longer one
  function automatic logic [15:0] line_offset();
    if ($urandom_range(19) == 0) return 16'($signed($urandom_range(200)) - 100);
    return 16'($signed($urandom_range(24)) - 12);
  endfunction

  task automatic run_phase(input int n_beats, input int gap_pct, input int stall_pct);
    int stop_at;
    int kind;
    logic [15:0] sx, sy;
    send_gap_pct = gap_pct;
    recv_stall_pct = stall_pct;
    stop_at = beats_sent + n_beats;
    while (beats_sent < stop_at) begin
      kind = $urandom_range(99);
      sx = 16'($urandom);
      sy = 16'($urandom);
      if (kind < 75) begin
        // whole line; a start near the wrap can make a huge line, capped
        draw_line(sx, sy, sx + line_offset(), sy + line_offset(), 64);
      end else if (kind < 85) begin
        // arbitrary endpoints, abandoned after a few pixels
        draw_line(sx, sy, 16'($urandom), 16'($urandom), $urandom_range(5));
      end else if (kind < 95) begin
        repeat ($urandom_range(3, 1)) send_step();
      end else begin
        drain();
      end
    end
    drain();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    write_mask(16'hFFFF);

    // directed: idle step at the origin, zero length, extremes, several octants
    send_step();
    draw_line(16'sd5, 16'sd5, 16'sd5, 16'sd5, 4);
    send_step();
    draw_line(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 3);
    draw_line(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 2);
    draw_line(16'sd0, 16'sd0, 16'sd3, -16'sd1, 8);
    draw_line(-16'sd2, 16'sd1, -16'sd2, -16'sd2, 8);
    draw_line(16'sd10, 16'sd10, 16'sd8, 16'sd12, 8);
    drain();
    write_mask(16'h0000);
    draw_line(16'sd1, 16'sd1, 16'sd3, 16'sd2, 8);
    drain();

    // random: sender light and receiver heavy, then swapped, then no idling
    write_mask(16'($urandom));
    run_phase(250, 9, 48);
    write_mask(16'h00FF);
    run_phase(250, 48, 9);
    write_mask(16'($urandom));
    run_phase(250, 0, 0);

    for (int i = 0; i < 10000 && sb.pending() != 0; i++) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
